@@ rtl/e2g_pkg.sv @@
// ----------------------------------------------------------------------------
// e2g_pkg
// Types, constants and small tables shared by the Ethiopian to Gregorian
// date conversion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package e2g_pkg;

	// Field widths
	localparam int EDAY_W   = 5;
	localparam int EMON_W   = 4;
	localparam int EYEAR_W  = 14;
	localparam int GYEAR_W  = 15;   // internal year, holds eth year + 7 or + 8
	localparam int REM_W    = 9;    // day offset inside the Ethiopian year
	localparam int SUM_W    = 11;   // Zeller sum before mod 7
	localparam int IN_W     = 24;
	localparam int OUT_W    = 32;

	// Shared multiplier operands
	localparam int MUL_A_W  = 15;
	localparam int MUL_B_W  = 13;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	// Reciprocal constants: floor(x/100) = (x*5243)>>19 for x < 2^15,
	// floor(x/7) = (x*2341)>>14 for x < 2^11
	localparam logic [MUL_B_W-1:0] RECIP100    = 13'd5243;
	localparam int                 RECIP100_SH = 19;
	localparam logic [MUL_B_W-1:0] RECIP7      = 13'd2341;
	localparam int                 RECIP7_SH   = 14;

	localparam logic [EMON_W-1:0] MON_JAN   = 4'd1;
	localparam logic [EMON_W-1:0] MON_FEB   = 4'd2;
	localparam logic [EMON_W-1:0] MON_MAR   = 4'd3;
	localparam logic [EMON_W-1:0] MON_SEP   = 4'd9;
	localparam logic [EMON_W-1:0] MON_DEC   = 4'd12;
	localparam logic [EMON_W-1:0] MON_PAGUME = 4'd13;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAP_MUL,
		ST_LEAP_CHK,
		ST_WALK,
		ST_ZDIV,
		ST_ZSUM,
		ST_ZMOD,
		ST_ZFIN,
		ST_DONE
	} state_t;

	// Multiplier operand select
	typedef enum logic [1:0] {
		MSEL_YEAR_NEXT,
		MSEL_YEAR_Z,
		MSEL_SUM
	} mul_sel_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic     in_ready;
		logic     ld_leap;
		logic     walk;
		logic     ld_sum;
		logic     ld_wd;
		logic     out_load;
		mul_sel_t mul_sel;
	} ctrl_t;

	// Datapath to sequencer status
	typedef struct packed {
		logic in_valid;
		logic date_ok;
		logic walk_last;
		logic out_free;
	} stat_t;

	// Gregorian month length
	function automatic logic [4:0] greg_month_len(input logic [EMON_W-1:0] m,
			input logic leap);
		logic [4:0] len;
		begin
			case (m)
				MON_FEB: len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

	// Zeller month term floor(13*(m+1)/5), m in 3..14
	function automatic logic [5:0] zeller_mterm(input logic [EMON_W-1:0] m);
		logic [5:0] t;
		begin
			case (m)
				4'd3:    t = 6'd10;
				4'd4:    t = 6'd13;
				4'd5:    t = 6'd15;
				4'd6:    t = 6'd18;
				4'd7:    t = 6'd20;
				4'd8:    t = 6'd23;
				4'd9:    t = 6'd26;
				4'd10:   t = 6'd28;
				4'd11:   t = 6'd31;
				4'd12:   t = 6'd33;
				4'd13:   t = 6'd36;
				4'd14:   t = 6'd39;
				default: t = 6'd0;
			endcase
			return t;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/e2g_mul.sv @@
// ----------------------------------------------------------------------------
// e2g_mul
// Shared reciprocal multiplier, product registered. Serves the /100 for the
// leap check and for Zeller, and the mod 7 of the weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_mul (
	input  wire                              clk,
	input  wire  [e2g_pkg::MUL_A_W-1:0]      a,
	input  wire  [e2g_pkg::MUL_B_W-1:0]      b,
	output logic [e2g_pkg::MUL_P_W-1:0]      p
);
	import e2g_pkg::*;

	logic [MUL_P_W-1:0] prod_q;

	// One multiply per cycle
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = prod_q;

endmodule

`default_nettype wire

@@ rtl/e2g_seq.sv @@
// ----------------------------------------------------------------------------
// e2g_seq
// Sequencer: leap check, month walk, Zeller weekday and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire e2g_pkg::stat_t stat,
	output e2g_pkg::ctrl_t  ctrl
);
	import e2g_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) begin
					state_d = stat.date_ok ? ST_LEAP_MUL : ST_DONE;
				end
			end
			ST_LEAP_MUL: state_d = ST_LEAP_CHK;
			ST_LEAP_CHK: state_d = ST_WALK;
			ST_WALK: begin
				if (stat.walk_last) begin
					state_d = ST_ZDIV;
				end
			end
			ST_ZDIV: state_d = ST_ZSUM;
			ST_ZSUM: state_d = ST_ZMOD;
			ST_ZMOD: state_d = ST_ZFIN;
			ST_ZFIN: state_d = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MSEL_YEAR_NEXT;
		case (state_q)
			ST_IDLE:     ctrl.in_ready = 1'b1;
			ST_LEAP_MUL: ctrl.mul_sel = MSEL_YEAR_NEXT;
			ST_LEAP_CHK: ctrl.ld_leap = 1'b1;
			ST_WALK:     ctrl.walk = 1'b1;
			ST_ZDIV:     ctrl.mul_sel = MSEL_YEAR_Z;
			ST_ZSUM:     ctrl.ld_sum = 1'b1;
			ST_ZMOD:     ctrl.mul_sel = MSEL_SUM;
			ST_ZFIN:     ctrl.ld_wd = 1'b1;
			ST_DONE:     ctrl.out_load = stat.out_free;
			default:     ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ethiopian_to_gregorian_date_unit.sv @@
// ----------------------------------------------------------------------------
// ethiopian_to_gregorian_date_unit
// Checks an Ethiopian date and converts it to a Gregorian date, weekday and
// Ethiopian leap flag. One item at a time.
// ----------------------------------------------------------------------------
// Sequence: a valid date passes the leap check, then the month walk, one step
//   per Gregorian month walked from the new year date, then the Zeller states,
//   then ST_DONE; an invalid date goes straight to ST_DONE. ST_DONE waits for
//   a free output register; a new item is taken once the result is registered.
// Reset: arst_n clears the sequencer and the output valid; payload is not reset.
`default_nettype none

module ethiopian_to_gregorian_date_unit (
	input  wire         clk,
	input  wire         arst_n,
	// Input: [4:0] eth_day_in, [8:5] eth_month_in, [22:9] eth_year_in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,
	// Output: [4:0] greg_day_out, [8:5] greg_month_out, [22:9] greg_year_out,
	//         [25:23] weekday_out, [26] eth_leap_out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,
	// Output user: [0] date_valid
	output logic        m_tuser
);
	import e2g_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	// Input fields
	logic [EDAY_W-1:0]  eday;
	logic [EMON_W-1:0]  emon;
	logic [EYEAR_W-1:0] eyear;
	logic               eleap;
	logic [4:0]         emlen;
	logic               date_ok;
	logic [REM_W-1:0]   emon_m1;
	logic [REM_W-1:0]   offset;

	// Working registers
	logic               valid_q;
	logic               eleap_q;
	logic [GYEAR_W-1:0] gy_q;
	logic [EMON_W-1:0]  gm_q;
	logic [EDAY_W-1:0]  gd_q;
	logic [REM_W-1:0]   rem_q;
	logic               glp_q;
	logic [SUM_W-1:0]   sum_q;
	logic [2:0]         wd_q;

	// Output register
	logic               out_vld_q;
	logic               out_ok_q;
	logic [31:0]        out_data_q;

	assign eday  = s_tdata[4:0];
	assign emon  = s_tdata[8:5];
	assign eyear = s_tdata[22:9];
	assign eleap = (eyear[1:0] == 2'b11);

	// Date check
	always_comb begin
		if (emon >= MON_JAN && emon <= MON_DEC) begin
			emlen = 5'd30;
		end else if (emon == MON_PAGUME) begin
			emlen = eleap ? 5'd6 : 5'd5;
		end else begin
			emlen = 5'd0;
		end
	end
	assign date_ok = (emlen != 5'd0) && (eday != 5'd0) && (eday <= emlen);

	// Day offset: (month-1)*30 + day-1
	assign emon_m1 = REM_W'(emon) - REM_W'(1);
	assign offset  = (emon_m1 << 5) - (emon_m1 << 1) + REM_W'(eday) - REM_W'(1);

	assign s_tready = ctrl.in_ready;

	assign stat.in_valid = s_tvalid;
	assign stat.date_ok  = date_ok;
	assign stat.out_free = !out_vld_q || m_tready;

	e2g_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Leap check of the following Gregorian year
	logic [GYEAR_W-1:0] gy_next;
	logic [8:0]         lq;
	logic [GYEAR_W-1:0] lq100;
	logic [6:0]         lr;
	logic               glp;

	assign gy_next = gy_q + GYEAR_W'(1);
	assign lq      = mul_p[RECIP100_SH +: 9];
	assign lq100   = GYEAR_W'(lq) * GYEAR_W'(100);
	assign lr      = 7'(gy_next - lq100);
	assign glp     = (gy_next[1:0] == 2'b00) && ((lr != 7'd0) || (lq[1:0] == 2'b00));

	// Month walk step
	logic [4:0]       mlen;
	logic [4:0]       room;
	logic             walk_last;

	assign mlen      = greg_month_len(gm_q, glp_q);
	assign room      = mlen - gd_q;
	assign walk_last = (rem_q <= REM_W'(room));
	assign stat.walk_last = walk_last;

	// Zeller operands
	logic               early;
	logic [GYEAR_W-1:0] yz;
	logic [EMON_W-1:0]  mz;
	logic [8:0]         zj;
	logic [GYEAR_W-1:0] zj100;
	logic [6:0]         zk;
	logic [SUM_W-1:0]   zsum;

	assign early = (gm_q < MON_MAR);
	assign yz    = early ? gy_q - GYEAR_W'(1) : gy_q;
	assign mz    = early ? gm_q + EMON_W'(12) : gm_q;
	assign zj    = mul_p[RECIP100_SH +: 9];
	assign zj100 = GYEAR_W'(zj) * GYEAR_W'(100);
	assign zk    = 7'(yz - zj100);
	assign zsum  = SUM_W'(gd_q) + SUM_W'(zeller_mterm(mz)) + SUM_W'(zk)
	             + SUM_W'(zk >> 2) + SUM_W'(zj >> 2) + SUM_W'(zj) * SUM_W'(5);

	// Weekday from the sum mod 7
	logic [SUM_W-1:0] q7;
	logic [2:0]       r7;

	assign q7 = mul_p[RECIP7_SH +: SUM_W];
	assign r7 = 3'(sum_q - q7 * SUM_W'(7));

	// Shared multiplier operand select
	always_comb begin
		case (ctrl.mul_sel)
			MSEL_YEAR_NEXT: begin
				mul_a = gy_next;
				mul_b = RECIP100;
			end
			MSEL_YEAR_Z: begin
				mul_a = yz;
				mul_b = RECIP100;
			end
			MSEL_SUM: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = RECIP7;
			end
			default: begin
				mul_a = gy_next;
				mul_b = RECIP100;
			end
		endcase
	end

	e2g_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Working datapath
	always_ff @(posedge clk) begin
		if (ctrl.in_ready && s_tvalid) begin
			valid_q <= date_ok;
			eleap_q <= eleap;
			gy_q    <= GYEAR_W'(eyear) + GYEAR_W'(7);
			gm_q    <= MON_SEP;
			rem_q   <= offset;
			wd_q    <= 3'd0;
		end
		if (ctrl.ld_leap) begin
			glp_q <= glp;
			gd_q  <= glp ? 5'd12 : 5'd11;
		end
		if (ctrl.walk) begin
			if (walk_last) begin
				gd_q  <= gd_q + rem_q[4:0];
				rem_q <= '0;
			end else begin
				rem_q <= rem_q - REM_W'(room) - REM_W'(1);
				gd_q  <= 5'd1;
				if (gm_q == MON_DEC) begin
					gm_q <= MON_JAN;
					gy_q <= gy_q + GYEAR_W'(1);
				end else begin
					gm_q <= gm_q + EMON_W'(1);
				end
			end
		end
		if (ctrl.ld_sum) begin
			sum_q <= zsum;
		end
		if (ctrl.ld_wd) begin
			wd_q <= (r7 == 3'd0) ? 3'd6 : r7 - 3'd1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_ok_q <= valid_q;
			if (valid_q) begin
				out_data_q <= {5'd0, eleap_q, wd_q, gy_q[EYEAR_W-1:0], gm_q, gd_q};
			end else begin
				out_data_q <= {5'd0, eleap_q, 26'd0};
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ok_q;

	// Checks
	a_take_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two cycles in a row");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[25:0] == 26'd0)
		else $error("invalid date with nonzero date fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[8:5] != 4'd0 && m_tdata[8:5] <= MON_DEC
			&& m_tdata[4:0] != 5'd0 && m_tdata[25:23] != 3'd7)
		else $error("converted date out of range");

	a_walk_day: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.walk |-> gd_q <= mlen && gd_q != 5'd0)
		else $error("month walk day beyond month length");

endmodule

`default_nettype wire
